// File: src/assert_macros.svh
// Assertion macros for the RTL file of the line pixel walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: src/lpw_pkg.sv
// Package with the widths and request codes of the line pixel walker.
`default_nettype none

package lpw_pkg;

  // Width of one pixel coordinate.
  localparam int COORD_BITS = 12;

  // Width of an offset-by-span cross product.
  localparam int PROD_BITS = 2 * COORD_BITS;

  // Request codes carried by req_type.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

endpackage : lpw_pkg

`default_nettype wire

// File: src/line_pixel_walker_unit.sv
// Top level of the line pixel walker: a 4-connected line rasterizer.
//
//   Channel | Ports                                        | Direction
//   --------+----------------------------------------------+----------
//   input   | in_valid/in_ready, in_req_type, in_x_start,  | in
//           | in_y_start, in_x_end, in_y_end               |
//   output  | out_valid/out_ready, out_pixel_x,            | out
//           | out_pixel_y, out_last_pixel                  |
//
// A step transaction has its pixel in the output register in the cycle after it is
// accepted, so the block sustains one pixel per clock while out_ready is high; running
// cross product registers replace both multiplies with one add each.
// Reset (rst_n low, synchronous) drops any active line and empties the output.
// While a result sits in the output register and out_ready is low, in_ready
// is held low; otherwise a new transaction is taken every cycle.
`default_nettype none

`include "assert_macros.svh"

module line_pixel_walker_unit
  import lpw_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,

  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   in_req_type,
  input  wire  [COORD_BITS-1:0] in_x_start,
  input  wire  [COORD_BITS-1:0] in_y_start,
  input  wire  [COORD_BITS-1:0] in_x_end,
  input  wire  [COORD_BITS-1:0] in_y_end,

  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_last_pixel
);

  // Line state. The base point is the end with the smaller y (the left end
  // for a flat line); the offsets count how far the walk has gone from it.
  logic                  line_active_r, line_active_nxt;
  logic                  flat_mode_r,   flat_mode_nxt;
  logic                  x_leftward_r,  x_leftward_nxt;
  logic [COORD_BITS-1:0] base_x_r,      base_x_nxt;
  logic [COORD_BITS-1:0] base_y_r,      base_y_nxt;
  logic [COORD_BITS-1:0] span_x_r,      span_x_nxt;
  logic [COORD_BITS-1:0] span_y_r,      span_y_nxt;
  logic [COORD_BITS-1:0] x_offset_r,    x_offset_nxt;
  logic [COORD_BITS-1:0] y_offset_r,    y_offset_nxt;

  // Running cross products: lhs tracks x_offset * span_y and rhs tracks
  // y_offset * span_x. Each step adds one span to one of them, so the slope
  // test never needs a multiplier. The walk never overshoots a span, so the
  // sums stay below 2^PROD_BITS.
  logic [PROD_BITS-1:0]  lhs_r,         lhs_nxt;
  logic [PROD_BITS-1:0]  rhs_r,         rhs_nxt;

  // Output register.
  logic                  out_valid_r,   out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r,       out_x_nxt;
  logic [COORD_BITS-1:0] out_y_r,       out_y_nxt;
  logic                  out_last_r,    out_last_nxt;

  // Handshake: a new transaction is taken unless a stalled result blocks the
  // output register.
  logic in_accept;
  logic step_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign step_fire = in_accept && (in_req_type == REQ_STEP) && line_active_r;

  // Endpoint ordering for a start transaction.
  logic                  swap_ends;
  logic [COORD_BITS-1:0] ld_bx, ld_by, ld_fx, ld_fy;

  assign swap_ends = (in_y_end < in_y_start) ||
                     ((in_y_end == in_y_start) && (in_x_end < in_x_start));
  assign ld_bx = swap_ends ? in_x_end   : in_x_start;
  assign ld_by = swap_ends ? in_y_end   : in_y_start;
  assign ld_fx = swap_ends ? in_x_start : in_x_end;
  assign ld_fy = swap_ends ? in_y_start : in_y_end;

  // Current pixel of the active line and its end-of-line flag.
  logic [COORD_BITS-1:0] cur_x, cur_y;
  logic                  cur_last;
  logic                  move_y;

  assign cur_x    = x_leftward_r ? (base_x_r - x_offset_r) : (base_x_r + x_offset_r);
  assign cur_y    = base_y_r + y_offset_r;
  assign cur_last = (x_offset_r == span_x_r) && (y_offset_r == span_y_r);

  // Step in y while the path lies on or left of the ideal line and y still
  // has room; otherwise step in x toward the far end. A flat line only
  // ever steps in x.
  assign move_y = !flat_mode_r && (lhs_r >= rhs_r) && (y_offset_r < span_y_r);

  always_comb begin
    line_active_nxt = line_active_r;
    flat_mode_nxt   = flat_mode_r;
    x_leftward_nxt  = x_leftward_r;
    base_x_nxt      = base_x_r;
    base_y_nxt      = base_y_r;
    span_x_nxt      = span_x_r;
    span_y_nxt      = span_y_r;
    x_offset_nxt    = x_offset_r;
    y_offset_nxt    = y_offset_r;
    lhs_nxt         = lhs_r;
    rhs_nxt         = rhs_r;

    out_valid_nxt   = out_valid_r && !out_ready;
    out_x_nxt       = out_x_r;
    out_y_nxt       = out_y_r;
    out_last_nxt    = out_last_r;

    if (in_accept && (in_req_type == REQ_START)) begin
      // A start replaces any line still in progress and gives no result.
      base_x_nxt      = ld_bx;
      base_y_nxt      = ld_by;
      span_y_nxt      = ld_fy - ld_by;
      x_leftward_nxt  = ld_fx < ld_bx;
      span_x_nxt      = (ld_fx < ld_bx) ? (ld_bx - ld_fx) : (ld_fx - ld_bx);
      flat_mode_nxt   = (ld_fy == ld_by);
      x_offset_nxt    = '0;
      y_offset_nxt    = '0;
      lhs_nxt         = '0;
      rhs_nxt         = '0;
      line_active_nxt = 1'b1;
    end else if (step_fire) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = cur_x;
      out_y_nxt     = cur_y;
      out_last_nxt  = cur_last;
      if (cur_last) begin
        line_active_nxt = 1'b0;
      end else if (move_y) begin
        y_offset_nxt = y_offset_r + COORD_BITS'(1);
        rhs_nxt      = rhs_r + PROD_BITS'(span_x_r);
      end else begin
        x_offset_nxt = x_offset_r + COORD_BITS'(1);
        lhs_nxt      = lhs_r + PROD_BITS'(span_y_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
      flat_mode_r   <= 1'b0;
      x_leftward_r  <= 1'b0;
      base_x_r      <= '0;
      base_y_r      <= '0;
      span_x_r      <= '0;
      span_y_r      <= '0;
      x_offset_r    <= '0;
      y_offset_r    <= '0;
      lhs_r         <= '0;
      rhs_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      line_active_r <= line_active_nxt;
      flat_mode_r   <= flat_mode_nxt;
      x_leftward_r  <= x_leftward_nxt;
      base_x_r      <= base_x_nxt;
      base_y_r      <= base_y_nxt;
      span_x_r      <= span_x_nxt;
      span_y_r      <= span_y_nxt;
      x_offset_r    <= x_offset_nxt;
      y_offset_r    <= y_offset_nxt;
      lhs_r         <= lhs_nxt;
      rhs_r         <= rhs_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Result payload needs no reset: it is only looked at with out_valid.
  always_ff @(posedge clk) begin
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = out_x_r;
  assign out_pixel_y    = out_y_r;
  assign out_last_pixel = out_last_r;

  // Terms for the checks below, formed at full product width.
  logic                 offsets_in_span;
  logic [PROD_BITS-1:0] lhs_exact, rhs_exact;
  logic                 cross_ok;
  logic                 last_closed;

  assign offsets_in_span = (x_offset_r <= span_x_r) && (y_offset_r <= span_y_r);
  assign lhs_exact       = PROD_BITS'(x_offset_r) * PROD_BITS'(span_y_r);
  assign rhs_exact       = PROD_BITS'(y_offset_r) * PROD_BITS'(span_x_r);
  assign cross_ok        = (lhs_r == lhs_exact) && (rhs_r == rhs_exact);
  assign last_closed     = !line_active_r && out_valid_r && out_last_r;

  // The walk never runs past either span while a line is active.
  `ASSERT_IMPLIES(a_offsets_in_span, clk, rst_n, line_active_r, offsets_in_span)

  // The running sums always equal the true cross products.
  `ASSERT_IMPLIES(a_cross_products, clk, rst_n, 1'b1, cross_ok)

  // Emitting the end point closes the line.
  `ASSERT_NEXT(a_last_ends_line, clk, rst_n, step_fire && cur_last, last_closed)

endmodule : line_pixel_walker_unit

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for line_pixel_walker_unit: directed and random line walks.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpw_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;

  // One plotted pixel as the block should present it.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // Tracks the line being walked and the pixels still owed by the block.
  // Every accepted request transaction goes through note_request; every
  // accepted result transaction goes through check_pixel.
  class pixel_scoreboard;
    bit     line_on;
    bit     flat;
    bit     leftward;
    coord_t base_x, base_y, span_x, span_y, x_off, y_off;
    pixel_t pixel_q[$];
    int     mismatches;
    int     pixels_seen;
    int     lines_loaded;
    int     lines_done;
    int     steps_ignored;

    function void note_request(logic req, coord_t xs, coord_t ys, coord_t xe, coord_t ye);
      coord_t               far_x, far_y;
      logic [PROD_BITS-1:0] x_cross, y_cross;
      pixel_t               p;
      if (req == REQ_START) begin
        // The base is the end with the lower y, or the left end when y ties.
        if (ye < ys || (ye == ys && xe < xs)) begin
          base_x = xe;
          base_y = ye;
          far_x  = xs;
          far_y  = ys;
        end else begin
          base_x = xs;
          base_y = ys;
          far_x  = xe;
          far_y  = ye;
        end
        span_y   = far_y - base_y;
        leftward = far_x < base_x;
        span_x   = leftward ? base_x - far_x : far_x - base_x;
        flat     = (span_y == '0);
        x_off    = '0;
        y_off    = '0;
        line_on  = 1'b1;
        lines_loaded++;
        return;
      end
      if (!line_on) begin
        steps_ignored++;
        return;
      end
      p.x    = leftward ? base_x - x_off : base_x + x_off;
      p.y    = base_y + y_off;
      p.last = (x_off == span_x) && (y_off == span_y);
      pixel_q.push_back(p);
      if (p.last) begin
        line_on = 1'b0;
        lines_done++;
      end else if (flat) begin
        x_off++;
      end else begin
        // Move in y while the path lies on or left of the ideal line.
        x_cross = x_off * span_y;
        y_cross = y_off * span_x;
        if (x_cross >= y_cross && y_off < span_y) begin
          y_off++;
        end else begin
          x_off++;
        end
      end
    endfunction

    function void check_pixel(coord_t x, coord_t y, logic last);
      pixel_t want;
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: pixel (%0d,%0d) last=%0b arrived with none expected",
                 $time, x, y, last);
        return;
      end
      want = pixel_q.pop_front();
      if (x !== want.x) begin
        mismatches++;
        $display("%0t ns: pixel_x mismatch, expected %0d, actual %0d", $time, want.x, x);
      end
      if (y !== want.y) begin
        mismatches++;
        $display("%0t ns: pixel_y mismatch, expected %0d, actual %0d", $time, want.y, y);
      end
      if (last !== want.last) begin
        mismatches++;
        $display("%0t ns: last_pixel mismatch, expected %0b, actual %0b",
                 $time, want.last, last);
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  logic   in_req_type;
  coord_t in_x_start, in_y_start, in_x_end, in_y_end;
  logic   out_valid;
  logic   out_ready;
  coord_t out_pixel_x, out_pixel_y;
  logic   out_last_pixel;

  // When set, the matching side stops idling between transactions.
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  // Requests that the block acts on; ignored steps are not counted.
  int line_items = 0;

  pixel_scoreboard board = new;

  line_pixel_walker_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

  always #10 clk = ~clk;

  // Both channels are observed at the rising edge, where the stimulus set at
  // the previous falling edge is stable. The output is checked before the
  // input is noted: a request accepted at this edge cannot have its pixel on
  // the output yet, so the order never hides a missing expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        board.check_pixel(out_pixel_x, out_pixel_y, out_last_pixel);
      end
      if (in_valid && in_ready) begin
        board.note_request(in_req_type, in_x_start, in_y_start, in_x_end, in_y_end);
      end
    end
  end

  // Result side: before each result it holds ready low for a random number of
  // cycles, then keeps ready high until a transaction completes. Burst
  // stretches with ready held high come and go at random.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        rx_burst = !rx_burst;
      end
      stall = rx_burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Presents one request transaction and returns at the rising edge that
  // accepts it. Valid is left high so that a back-to-back request keeps it
  // high; whoever idles next lowers it at the following falling edge.
  task automatic send_request(logic req, coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_x_start  <= xs;
    in_y_start  <= ys;
    in_x_end    <= xe;
    in_y_end    <= ye;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic send_start(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    send_request(REQ_START, xs, ys, xe, ye);
    line_items++;
  endtask

  // Step requests carry random coordinates, which the block must ignore.
  task automatic send_steps(int count, bit counted);
    repeat (count) begin
      send_request(REQ_STEP, coord_t'($urandom), coord_t'($urandom),
                   coord_t'($urandom), coord_t'($urandom));
      if (counted) begin
        line_items++;
      end
    end
  endtask

  // Holds the request side idle until every owed pixel has been delivered.
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pixel_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Moves a coordinate by an offset, stopping at the edges of the range.
  function automatic coord_t shift_coord(coord_t c, int delta);
    int moved;
    moved = int'(c) + delta;
    if (moved < 0) begin
      return '0;
    end
    if (moved > (1 << COORD_BITS) - 1) begin
      return '1;
    end
    return coord_t'(moved);
  endfunction

  // Random signed offset whose magnitude lies in [lo, hi].
  function automatic int random_offset(int lo, int hi);
    int mag;
    mag = $urandom_range(lo, hi);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // Number of pixels in the 4-connected path between two points.
  function automatic int path_pixels(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    int ax, ay;
    ax = int'(xe) - int'(xs);
    ay = int'(ye) - int'(ys);
    return (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + 1;
  endfunction

  initial begin
    coord_t xs, ys, xe, ye;
    int     kind;
    int     guard;
    in_valid    = 1'b0;
    in_req_type = REQ_STEP;
    in_x_start  = '0;
    in_y_start  = '0;
    in_x_end    = '0;
    in_y_end    = '0;
    rst_n       = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A step with no line loaded must be dropped silently.
    send_steps(1, 1'b0);
    // A single-point line at the top corner ends on its first pixel, and a
    // step after the end is dropped again.
    send_start('1, '1, '1, '1);
    send_steps(1, 1'b1);
    send_steps(1, 1'b0);
    // Vertical line given top end first: the walk starts from the low y end.
    send_start('0, coord_t'(2), '0, '0);
    send_steps(3, 1'b1);
    // Flat line given right end first: the walk starts from the left end.
    send_start(coord_t'(3), '0, '0, '0);
    send_steps(4, 1'b1);
    // Line whose far end lies to the left of its base, at the high corner.
    send_start('1, coord_t'(4094), coord_t'(4093), '1);
    send_steps(4, 1'b1);
    // A full-diagonal line cut short by a new start, which then completes.
    send_start('0, '0, '1, '1);
    send_steps(2, 1'b1);
    send_start(coord_t'(1), coord_t'(1), coord_t'(2), coord_t'(1));
    send_steps(2, 1'b1);
    pause_until_drained();

    // Random part. Most transactions are complete walks of short lines at
    // random places; the rest are special shapes, long lines abandoned part
    // way and stray steps after a line has ended.
    while (line_items < 1000) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_burst = !tx_burst;
      end
      kind = $urandom_range(0, 19);
      xs   = coord_t'($urandom);
      ys   = coord_t'($urandom);
      if (kind < 17) begin
        if (kind < 14) begin
          xe = shift_coord(xs, random_offset(0, 12));
          ye = shift_coord(ys, random_offset(0, 12));
        end else if (kind == 14) begin
          xe = xs;
          ye = ys;
        end else if (kind == 15) begin
          xe = xs;
          ye = shift_coord(ys, random_offset(1, 30));
        end else begin
          xe = shift_coord(xs, random_offset(1, 30));
          ye = ys;
        end
        send_start(xs, ys, xe, ye);
        send_steps(path_pixels(xs, ys, xe, ye), 1'b1);
        if ($urandom_range(0, 3) == 0) begin
          send_steps($urandom_range(1, 2), 1'b0);
        end
      end else begin
        // Long line anywhere in the plane; the next start replaces it.
        send_start(xs, ys, coord_t'($urandom), coord_t'($urandom));
        send_steps($urandom_range(1, 20), 1'b1);
      end
      if ($urandom_range(0, 29) == 0) begin
        pause_until_drained();
      end
    end

    // One leftward line leaving the high x corner, walked to its end point.
    xs = '1;
    ys = '0;
    xe = coord_t'((1 << COORD_BITS) - 38);
    ye = coord_t'(23);
    send_start(xs, ys, xe, ye);
    send_steps(path_pixels(xs, ys, xe, ye), 1'b1);

    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (board.pixel_q.size() != 0 && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (board.pixel_q.size() != 0) begin
      board.mismatches += board.pixel_q.size();
      $display("%0t ns: %0d expected pixels never arrived", $time, board.pixel_q.size());
    end

    $display("Run covered %0d lines loaded and %0d walked to their end point,",
             board.lines_loaded, board.lines_done);
    $display("%0d pixels compared and %0d step requests correctly dropped.",
             board.pixels_seen, board.steps_ignored);
    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run with every side idling most.
  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
